### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the heading block. Define
// NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check prop at every rising edge of clk, ignored while rst is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Check prop at every rising edge of clk, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`else

`define ASSERT_CLK_RST(lbl, clk, rst, prop)
`define ASSERT_CLK(lbl, clk, prop)

`endif

`endif

### hdl/thdg_pkg.sv
// ----------------------------------------------------------------------------
// Target heading package
// Shared types, angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package thdg_pkg;

   // Datapath widths of the vectoring CORDIC
   localparam int CORDIC_W       = 38;
   localparam int ANGLE_Z_W      = 21;
   localparam int ATAN_TABLE_LEN = 24;

   // Angles: Q2.13 for results, Q.16 inside the CORDIC
   localparam int ANG_PI     = 25736;
   localparam int ANG_TWO_PI = 51472;
   localparam int PI_Q16     = 205887;

   // Result kinds
   localparam logic [1:0] RK_YAW     = 2'd0;
   localparam logic [1:0] RK_MID     = 2'd1;
   localparam logic [1:0] RK_HEADING = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_FOCAL_LENGTH   = 2'd0;
   localparam logic [1:0] CSR_OPTICAL_CENTER = 2'd1;
   localparam logic [1:0] CSR_CALIB_VALID    = 2'd2;
   localparam logic [1:0] CSR_SMOOTH_GAIN    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QMUL,
      ST_QCORD,
      ST_FILT,
      ST_LCORD,
      ST_RCORD,
      ST_SEND
   } thdg_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } thdg_cordic_status_type;

   // atan(2^-i) in Q.16 radians
   function automatic logic [16:0] atan_q16(input logic [4:0] idx);
      logic [16:0] val;
      unique case (idx)
         5'd0:    val = 17'd51472;
         5'd1:    val = 17'd30386;
         5'd2:    val = 17'd16055;
         5'd3:    val = 17'd8150;
         5'd4:    val = 17'd4091;
         5'd5:    val = 17'd2047;
         5'd6:    val = 17'd1024;
         5'd7:    val = 17'd512;
         5'd8:    val = 17'd256;
         5'd9:    val = 17'd128;
         5'd10:   val = 17'd64;
         5'd11:   val = 17'd32;
         5'd12:   val = 17'd16;
         5'd13:   val = 17'd8;
         5'd14:   val = 17'd4;
         5'd15:   val = 17'd2;
         5'd16:   val = 17'd1;
         default: val = 17'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

### hdl/thdg_cordic.sv
// ----------------------------------------------------------------------------
// Vectoring CORDIC
// atan2(vec_y, vec_x) in Q2.13, one micro-rotation per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module thdg_cordic #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic signed [thdg_pkg::CORDIC_W-1:0]   vec_y,
   input  wire logic signed [thdg_pkg::CORDIC_W-1:0]   vec_x,
   output thdg_pkg::thdg_cordic_status_type            status,
   output logic signed [15:0]                          angle
);

   localparam int NumSteps = (CORDIC_STEPS < thdg_pkg::ATAN_TABLE_LEN) ?
                             CORDIC_STEPS : thdg_pkg::ATAN_TABLE_LEN;
   localparam int StepW = $clog2(NumSteps);
   localparam int CW = thdg_pkg::CORDIC_W;
   localparam int ZW = thdg_pkg::ANGLE_Z_W;

   localparam logic signed [ZW-1:0] PiQ16     = ZW'(thdg_pkg::PI_Q16);
   localparam logic signed [ZW-1:0] RoundBias = ZW'(4);
   localparam logic signed [ZW-1:0] PosLimit  = ZW'(thdg_pkg::ANG_PI);
   localparam logic signed [ZW-1:0] NegLimit  = -PosLimit;

   logic signed [CW-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [CW-1:0] vx_shift, vy_shift;
   logic signed [ZW-1:0] z_ff, z_in;
   logic signed [ZW-1:0] atan_step, z_sum, z_round;
   logic [StepW-1:0]     step_ff, step_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic                 zero_ff, zero_in;
   logic                 last_step;

   always_comb begin
      vx_shift  = vx_ff >>> step_ff;
      vy_shift  = vy_ff >>> step_ff;
      atan_step = $signed(ZW'(thdg_pkg::atan_q16(5'(step_ff))));
      last_step = (step_ff == StepW'(NumSteps - 1));

      vx_in   = vx_ff;
      vy_in   = vy_ff;
      z_in    = z_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      zero_in = zero_ff;

      if (start) begin
         zero_in = (vec_x == '0) && (vec_y == '0);
         step_in = '0;
         run_in  = 1'b1;
         // fold the left half-plane onto the right one
         if (vec_x[CW-1]) begin
            vx_in = -vec_x;
            vy_in = -vec_y;
            z_in  = vec_y[CW-1] ? -PiQ16 : PiQ16;
         end else begin
            vx_in = vec_x;
            vy_in = vec_y;
            z_in  = '0;
         end
      end else if (run_ff) begin
         // rotate toward y = 0
         if (!vy_ff[CW-1] && (vy_ff != '0)) begin
            vx_in = vx_ff + vy_shift;
            vy_in = vy_ff - vx_shift;
            z_in  = z_ff + atan_step;
         end else begin
            vx_in = vx_ff - vy_shift;
            vy_in = vy_ff + vx_shift;
            z_in  = z_ff - atan_step;
         end
         step_in = step_ff + StepW'(1);
         run_in  = !last_step;
         done_in = last_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      zero_ff <= zero_in;
   end

   // round Q.16 to Q2.13 and clamp to +-pi; a zero input vector gives 0
   always_comb begin
      z_sum   = z_ff + RoundBias;
      z_round = z_sum >>> 3;
      if (zero_ff) begin
         angle = '0;
      end else if (z_round > PosLimit) begin
         angle = PosLimit[15:0];
      end else if (z_round < NegLimit) begin
         angle = NegLimit[15:0];
      end else begin
         angle = z_round[15:0];
      end
   end

   assign status.busy = run_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

### hdl/target_heading_from_imu_and_camera_top.sv
// ----------------------------------------------------------------------------
// Target heading from IMU and camera
// Filtered IMU yaw, mid-goal bearing and goal heading on one shared CORDIC.
// ----------------------------------------------------------------------------
// A request is either a quaternion (req_kind 0) or a goalpost pixel pair
// (req_kind 1). One request is processed at a time and req_ready is low from
// acceptance until its last response is taken. The arctangents run on
// one vectoring CORDIC that retires one micro-rotation per clock, and one
// 18x18 multiplier serves the quaternion terms and the yaw filter. A
// quaternion response follows the multiply steps, the CORDIC and the yaw
// filter; the first one loads the estimate directly and skips the filter.
// A post pair runs the CORDIC twice before its bearing response; the
// heading response, when an estimate exists, follows in the cycle after the
// bearing is taken. A post pair with calibration_valid low gives no response
// and leaves the block ready. CORDIC_STEPS above 24 runs 24 steps.
// Registers: 0 focal_length, 1 optical_center, 2 calibration_valid,
// 3 smoothing_gain; write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module target_heading_from_imu_and_camera_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_kind,
   input  wire logic signed [15:0] req_quat_x,
   input  wire logic signed [15:0] req_quat_y,
   input  wire logic signed [15:0] req_quat_z,
   input  wire logic signed [15:0] req_quat_w,
   input  wire logic [11:0]        req_left_px,
   input  wire logic [11:0]        req_right_col,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_result_kind,
   output logic signed [15:0]      rsp_angle,
   output logic                    rsp_last_of_run,
   // register write channel
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);

   localparam int CW = thdg_pkg::CORDIC_W;

   localparam logic [2:0] MulLastQuat = 3'd5;
   localparam logic [2:0] MulLastFilt = 3'd3;

   localparam logic signed [CW-1:0] QuatOne   = CW'(268435456);
   localparam logic signed [33:0]   FiltRound = 34'(32768);
   localparam logic signed [17:0]   HeadPos   = 18'(thdg_pkg::ANG_PI);
   localparam logic signed [17:0]   HeadNeg   = -HeadPos;
   localparam logic signed [17:0]   HeadWrap  = 18'(thdg_pkg::ANG_TWO_PI);
   localparam logic [17:0]          GainOne   = 18'(65536);

   thdg_pkg::thdg_state_type state_ff, state_in;

   // control
   logic [2:0]  mstep_ff, mstep_in;
   logic        est_valid_ff, est_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] fx_ff, cx_ff, gain_ff;
   logic        cal_ff;

   // datapath
   logic signed [15:0] qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in, qw_ff, qw_in;
   logic [11:0]        rpx_ff, rpx_in;
   logic signed [35:0] prod_ff, prod_in;
   logic signed [33:0] acca_ff, acca_in, accb_ff, accb_in;
   logic signed [15:0] yaw_ff, yaw_in, est_ff, est_in;
   logic signed [15:0] lb_ff, lb_in, mid_ff, mid_in;
   logic [1:0]         rsp_kind_ff, rsp_kind_in;
   logic signed [15:0] rsp_angle_ff, rsp_angle_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               req_acc, rsp_acc;
   logic signed [17:0] mul_a, mul_b;
   logic signed [CW-1:0] s_vec, c_vec, den_vec, bear_vec;
   logic signed [CW-1:0] cord_y, cord_x;
   logic               cord_start;
   logic signed [15:0] cord_angle;
   thdg_pkg::thdg_cordic_status_type cord_status;
   logic [11:0]        bear_px;
   logic signed [17:0] bear_num;
   logic signed [33:0] filt_sum;
   logic signed [16:0] mid_sum;
   logic signed [17:0] head_sum, head_wrap;
   logic               cord_phase, rsp_more, rsp_head;

   assign req_ready = (state_ff == thdg_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_acc   = req_valid && req_ready;
   assign rsp_acc   = rsp_valid_ff && rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_angle       = rsp_angle_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // CORDIC operands: quaternion s and c, or a pinhole bearing vector
   assign s_vec    = {{(CW - 35){acca_ff[33]}}, acca_ff, 1'b0};
   assign c_vec    = QuatOne - {{(CW - 35){accb_ff[33]}}, accb_ff, 1'b0};
   assign den_vec  = {{(CW - 32){1'b0}}, fx_ff, 16'h0000};
   assign bear_px  = (state_ff == thdg_pkg::ST_IDLE) ? req_left_px : rpx_ff;
   assign bear_num = {2'b00, bear_px, 4'h0} - {2'b00, cx_ff};
   assign bear_vec = {{(CW - 34){bear_num[17]}}, bear_num, 16'h0000};

   assign filt_sum  = acca_ff + FiltRound;
   assign mid_sum   = {lb_ff[15], lb_ff} + {cord_angle[15], cord_angle};
   assign head_sum  = {{2{est_ff[15]}}, est_ff} + {{2{mid_ff[15]}}, mid_ff};

   always_comb begin
      if (head_sum > HeadPos) begin
         head_wrap = head_sum - HeadWrap;
      end else if (head_sum < HeadNeg) begin
         head_wrap = head_sum + HeadWrap;
      end else begin
         head_wrap = head_sum;
      end
   end

   thdg_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cord_start),
      .vec_y  (cord_y),
      .vec_x  (cord_x),
      .status (cord_status),
      .angle  (cord_angle)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         thdg_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (!req_kind) begin
                  state_in = thdg_pkg::ST_QMUL;
               end else if (cal_ff) begin
                  state_in = thdg_pkg::ST_LCORD;
               end
            end
         end
         thdg_pkg::ST_QMUL: begin
            if (mstep_ff == MulLastQuat) begin
               state_in = thdg_pkg::ST_QCORD;
            end
         end
         thdg_pkg::ST_QCORD: begin
            if (cord_status.done) begin
               state_in = est_valid_ff ? thdg_pkg::ST_FILT : thdg_pkg::ST_SEND;
            end
         end
         thdg_pkg::ST_FILT: begin
            if (mstep_ff == MulLastFilt) begin
               state_in = thdg_pkg::ST_SEND;
            end
         end
         thdg_pkg::ST_LCORD: begin
            if (cord_status.done) begin
               state_in = thdg_pkg::ST_RCORD;
            end
         end
         thdg_pkg::ST_RCORD: begin
            if (cord_status.done) begin
               state_in = thdg_pkg::ST_SEND;
            end
         end
         thdg_pkg::ST_SEND: begin
            if (rsp_acc && rsp_last_ff) begin
               state_in = thdg_pkg::ST_IDLE;
            end
         end
         default: state_in = thdg_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs and datapath updates
   always_comb begin
      mstep_in     = '0;
      est_valid_in = est_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      qz_in        = qz_ff;
      qw_in        = qw_ff;
      rpx_in       = rpx_ff;
      acca_in      = acca_ff;
      accb_in      = accb_ff;
      yaw_in       = yaw_ff;
      est_in       = est_ff;
      lb_in        = lb_ff;
      mid_in       = mid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_angle_in = rsp_angle_ff;
      rsp_last_in  = rsp_last_ff;
      mul_a        = '0;
      mul_b        = '0;
      cord_start   = 1'b0;
      cord_y       = s_vec;
      cord_x       = c_vec;

      unique case (state_ff)
         thdg_pkg::ST_IDLE: begin
            if (req_acc) begin
               qx_in  = req_quat_x;
               qy_in  = req_quat_y;
               qz_in  = req_quat_z;
               qw_in  = req_quat_w;
               rpx_in = req_right_col;
               if (req_kind && cal_ff) begin
                  cord_start = 1'b1;
                  cord_y     = bear_vec;
                  cord_x     = den_vec;
               end
            end
         end
         thdg_pkg::ST_QMUL: begin
            mstep_in = mstep_ff + 3'd1;
            // multiply one step, accumulate the previous product
            unique case (mstep_ff)
               3'd0: begin
                  mul_a = {{2{qw_ff[15]}}, qw_ff};
                  mul_b = {{2{qz_ff[15]}}, qz_ff};
               end
               3'd1: begin
                  mul_a   = {{2{qx_ff[15]}}, qx_ff};
                  mul_b   = {{2{qy_ff[15]}}, qy_ff};
                  acca_in = 34'(prod_ff);
               end
               3'd2: begin
                  mul_a   = {{2{qy_ff[15]}}, qy_ff};
                  mul_b   = {{2{qy_ff[15]}}, qy_ff};
                  acca_in = acca_ff + 34'(prod_ff);
               end
               3'd3: begin
                  mul_a   = {{2{qz_ff[15]}}, qz_ff};
                  mul_b   = {{2{qz_ff[15]}}, qz_ff};
                  accb_in = 34'(prod_ff);
               end
               3'd4: begin
                  accb_in = accb_ff + 34'(prod_ff);
               end
               3'd5: begin
                  cord_start = 1'b1;
               end
               default: ;
            endcase
         end
         thdg_pkg::ST_QCORD: begin
            if (cord_status.done) begin
               yaw_in = cord_angle;
               if (!est_valid_ff) begin
                  // first sample loads the estimate directly
                  est_in       = cord_angle;
                  est_valid_in = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = thdg_pkg::RK_YAW;
                  rsp_angle_in = cord_angle;
                  rsp_last_in  = 1'b1;
               end
            end
         end
         thdg_pkg::ST_FILT: begin
            mstep_in = mstep_ff + 3'd1;
            unique case (mstep_ff)
               3'd0: begin
                  mul_a = {2'b00, gain_ff};
                  mul_b = {{2{yaw_ff[15]}}, yaw_ff};
               end
               3'd1: begin
                  mul_a   = GainOne - {2'b00, gain_ff};
                  mul_b   = {{2{est_ff[15]}}, est_ff};
                  acca_in = 34'(prod_ff);
               end
               3'd2: begin
                  acca_in = acca_ff + 34'(prod_ff);
               end
               3'd3: begin
                  est_in       = filt_sum[31:16];
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = thdg_pkg::RK_YAW;
                  rsp_angle_in = filt_sum[31:16];
                  rsp_last_in  = 1'b1;
               end
               default: ;
            endcase
         end
         thdg_pkg::ST_LCORD: begin
            if (cord_status.done) begin
               lb_in      = cord_angle;
               cord_start = 1'b1;
               cord_y     = bear_vec;
               cord_x     = den_vec;
            end
         end
         thdg_pkg::ST_RCORD: begin
            if (cord_status.done) begin
               mid_in       = mid_sum[16:1];
               rsp_valid_in = 1'b1;
               rsp_kind_in  = thdg_pkg::RK_MID;
               rsp_angle_in = mid_sum[16:1];
               rsp_last_in  = !est_valid_ff;
            end
         end
         thdg_pkg::ST_SEND: begin
            if (rsp_acc) begin
               if (rsp_last_ff) begin
                  rsp_valid_in = 1'b0;
               end else begin
                  // follow the bearing with the goal heading
                  rsp_kind_in  = thdg_pkg::RK_HEADING;
                  rsp_angle_in = head_wrap[15:0];
                  rsp_last_in  = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= thdg_pkg::ST_IDLE;
         mstep_ff     <= '0;
         est_valid_ff <= 1'b0;
         est_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         fx_ff        <= 16'd8000;
         cx_ff        <= 16'd0;
         cal_ff       <= 1'b0;
         gain_ff      <= 16'd13107;
      end else begin
         state_ff     <= state_in;
         mstep_ff     <= mstep_in;
         est_valid_ff <= est_valid_in;
         est_ff       <= est_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               thdg_pkg::CSR_FOCAL_LENGTH:   fx_ff   <= csr_wdata;
               thdg_pkg::CSR_OPTICAL_CENTER: cx_ff   <= csr_wdata;
               thdg_pkg::CSR_CALIB_VALID:    cal_ff  <= csr_wdata[0];
               thdg_pkg::CSR_SMOOTH_GAIN:    gain_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      qz_ff        <= qz_in;
      qw_ff        <= qw_in;
      rpx_ff       <= rpx_in;
      prod_ff      <= prod_in;
      acca_ff      <= acca_in;
      accb_ff      <= accb_in;
      yaw_ff       <= yaw_in;
      lb_ff        <= lb_in;
      mid_ff       <= mid_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign cord_phase = (state_ff == thdg_pkg::ST_QCORD) || (state_ff == thdg_pkg::ST_LCORD) ||
                       (state_ff == thdg_pkg::ST_RCORD);
   assign rsp_more   = rsp_acc && !rsp_last_ff;
   assign rsp_head   = rsp_valid_ff && (rsp_kind_ff == thdg_pkg::RK_HEADING);

   `ASSERT_CLK(a_reset_clears, clock, reset |=> (!rsp_valid && req_ready))
   `ASSERT_CLK_RST(a_one_request, clock, reset, !(req_ready && rsp_valid))
   `ASSERT_CLK_RST(a_cordic_free, clock, reset, cord_start |-> !cord_status.busy)
   `ASSERT_CLK_RST(a_cordic_done, clock, reset, cord_status.done |-> cord_phase)
   `ASSERT_CLK_RST(a_heading_next, clock, reset, rsp_more |=> rsp_head)

endmodule

`default_nettype wire
